// ===== design/dmc_pkg.sv =====
package dmc_pkg;

	// Fixed geometry: the address field is 10 bits wide, so the store spans it.
	localparam int ADDR_W      = 10;
	localparam int DATA_W      = 32;
	localparam int CACHE_WORDS = 64;
	localparam int BLOCK_WORDS = 4;
	localparam int MEM_WORDS   = 1024;
	localparam int LINE_COUNT  = CACHE_WORDS / BLOCK_WORDS;
	localparam int OFF_W       = $clog2(BLOCK_WORDS);
	localparam int SLOT_W      = $clog2(CACHE_WORDS);
	localparam int LINE_W      = SLOT_W - OFF_W;
	localparam int TAG_W       = ADDR_W - SLOT_W;
	localparam int FUNC_W      = 3;
	localparam int PEN_W       = 8;

	// Operation codes carried in tuser.
	localparam logic [FUNC_W-1:0] FUNC_IREAD = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PROBE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_STORE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd4;

	// Per-word transfer costs after the first word.
	localparam logic [PEN_W-1:0] EARLY_WORD_COST = 8'd2;
	localparam logic [PEN_W-1:0] LATE_WORD_COST  = 8'd1;
	localparam logic [PEN_W-1:0] PENALTY_RESET   = 8'd10;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] access_total;
		logic [DATA_W-1:0] hit_total;
		logic [DATA_W-1:0] cycle_total;
		logic              hit;
		logic [DATA_W-1:0] read_data;
	} result_t;

endpackage

// ===== design/dmc_ram.sv =====
module dmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/dmc_ctrl.sv =====
module dmc_ctrl
	import dmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [PEN_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  item_t            in_item,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_FILL   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_STORE  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [PEN_W-1:0]  penalty_q;
	logic [FUNC_W-1:0] func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;
	logic              hit_bit_q;
	logic [OFF_W-1:0]  idx_q;
	logic              fill_wr_s1;
	logic [OFF_W-1:0]  idx_s1;
	logic [DATA_W-1:0] cycle_q;
	logic [DATA_W-1:0] hits_q;
	logic [DATA_W-1:0] access_q;
	logic [LINE_COUNT-1:0] line_valid_q;
	logic [TAG_W-1:0]  line_tag_q [LINE_COUNT];

	logic [OFF_W-1:0]  off;
	logic [LINE_W-1:0] line;
	logic [TAG_W-1:0]  tg;
	logic              found;
	logic [PEN_W-1:0]  cost;

	logic              cache_we;
	logic [SLOT_W-1:0] cache_waddr;
	logic [DATA_W-1:0] cache_wdata;
	logic              cache_re;
	logic [DATA_W-1:0] cache_rdata;
	logic              store_we;
	logic              store_re;
	logic [ADDR_W-1:0] store_raddr;
	logic [DATA_W-1:0] store_rdata;

	// Address split of the latched item.
	assign off   = addr_q[OFF_W-1:0];
	assign line  = addr_q[SLOT_W-1:OFF_W];
	assign tg    = addr_q[ADDR_W-1:SLOT_W];
	assign found = line_valid_q[line] && (line_tag_q[line] == tg);

	// Cost of the block word being fetched this cycle.
	always_comb begin
		if (idx_q == '0) begin
			cost = penalty_q;
		end else if (idx_q > off) begin
			cost = LATE_WORD_COST;
		end else begin
			cost = EARLY_WORD_COST;
		end
	end

	// Memory port control.
	assign store_re    = (state_q == S_FILL);
	assign store_raddr = {addr_q[ADDR_W-1:OFF_W], idx_q};
	assign store_we    = (state_q == S_STORE) ||
		((state_q == S_DECIDE) && (func_q == FUNC_LOAD));
	assign cache_re    = (state_q == S_READ);
	assign cache_we    = fill_wr_s1 || (state_q == S_STORE);
	assign cache_waddr = (state_q == S_STORE) ? addr_q[SLOT_W-1:0] : {line, idx_s1};
	assign cache_wdata = (state_q == S_STORE) ? wdata_q : store_rdata;

	dmc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MEM_WORDS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(addr_q),
		.wdata(wdata_q),
		.re   (store_re),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	dmc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CACHE_WORDS)
	) u_cache (
		.clk  (clk),
		.we   (cache_we),
		.waddr(cache_waddr),
		.wdata(cache_wdata),
		.re   (cache_re),
		.raddr(addr_q[SLOT_W-1:0]),
		.rdata(cache_rdata)
	);

	// Latched item payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q  <= in_item.func;
			addr_q  <= in_item.addr;
			wdata_q <= in_item.write_data;
		end
		idx_s1 <= idx_q;
	end

	// Sequencer, counters and line tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			penalty_q    <= PENALTY_RESET;
			hit_bit_q    <= 1'b0;
			idx_q        <= '0;
			fill_wr_s1   <= 1'b0;
			cycle_q      <= '0;
			hits_q       <= '0;
			access_q     <= '0;
			line_valid_q <= '0;
			for (int i = 0; i < LINE_COUNT; i++) begin
				line_tag_q[i] <= '0;
			end
		end else begin
			fill_wr_s1 <= (state_q == S_FILL);
			if (cfg_we) begin
				penalty_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					idx_q <= '0;
					case (func_q)
						FUNC_IREAD: begin
							hit_bit_q <= found;
							access_q  <= access_q + 1'b1;
							if (found) begin
								hits_q  <= hits_q + 1'b1;
								state_q <= S_READ;
							end else begin
								line_valid_q[line] <= 1'b1;
								line_tag_q[line]   <= tg;
								state_q            <= S_FILL;
							end
						end
						FUNC_PROBE: begin
							hit_bit_q <= found;
							access_q  <= access_q + 1'b1;
							state_q   <= S_DONE;
							if (found) begin
								hits_q <= hits_q + 1'b1;
							end
						end
						FUNC_FILL: begin
							hit_bit_q          <= 1'b0;
							access_q           <= access_q + 1'b1;
							line_valid_q[line] <= 1'b1;
							line_tag_q[line]   <= tg;
							state_q            <= S_FILL;
						end
						FUNC_STORE: begin
							hit_bit_q <= found;
							if (found) begin
								state_q <= S_STORE;
							end else begin
								line_valid_q[line] <= 1'b1;
								line_tag_q[line]   <= tg;
								state_q            <= S_FILL;
							end
						end
						default: begin
							hit_bit_q <= 1'b0;
							state_q   <= S_DONE;
						end
					endcase
				end
				S_FILL: begin
					cycle_q <= cycle_q + DATA_W'(cost);
					idx_q   <= idx_q + 1'b1;
					if (idx_q == OFF_W'(BLOCK_WORDS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= (func_q == FUNC_STORE) ? S_STORE : S_READ;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_STORE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Handshakes and result.
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res              = '0;
		res.hit          = hit_bit_q;
		res.cycle_total  = cycle_q;
		res.hit_total    = hits_q;
		res.access_total = access_q;
		if ((func_q == FUNC_IREAD) || (func_q == FUNC_FILL)) begin
			res.read_data = cache_rdata;
		end
	end

`ifndef SYNTHESIS
	a_decide_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECIDE))
		else $error("accepted item did not enter the decide step");

	a_no_store_write_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> !store_we)
		else $error("backing store written during a block fill");

	a_cache_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cache_we && cache_re))
		else $error("cache read and write in the same cycle");

	a_hit_only_for_lookups: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.hit) |->
		((func_q == FUNC_IREAD) || (func_q == FUNC_PROBE) || (func_q == FUNC_STORE)))
		else $error("hit reported for an operation without a lookup");

	a_fill_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> line_valid_q[line])
		else $error("line not marked valid while it is filled");
`endif

endmodule

// ===== design/direct_mapped_cache_timing_model.sv =====
// From accept to result: a probe, load or unknown code goes from the decide step to the
// result; a read hit or store hit adds one read or store step; a read or fill that moves a
// block and a store miss first fill the line (one block word fetched per cycle through the
// backing store read port, a drain), then take the read or store step. Throughput: one item
// at a time; the input is ready again as the result enters the output register.
// Reset (arst_n low, asynchronous): all lines invalid, counters zero, penalty 10;
// no clearing pass, cache and store data are undefined until written.
module direct_mapped_cache_timing_model
	import dmc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: first_word_penalty.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data,
	// Input beats.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,  // addr[9:0], write_data[41:10], zero fill
	input  logic [2:0]   s_tuser,  // func[2:0]
	// Result beats.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata   // read_data[31:0], hit[32], cycle_total[64:33],
	                               // hit_total[96:65], access_total[128:97], zero fill
);

	item_t   item;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	logic    res_valid;
	logic    res_ready;

	// Unpack the input beat.
	assign item.func       = s_tuser;
	assign item.addr       = s_tdata[ADDR_W-1:0];
	assign item.write_data = s_tdata[ADDR_W+DATA_W-1:ADDR_W];

	assign cfg_ready = 1'b1;

	dmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_wdata(cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register decouples the result side from the sequencer.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q};

endmodule
